// ===== hw/rtl/orient2d_sos_predicate_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the orientation predicate unit
// Shared macro forms for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef ORIENT2D_SOS_PREDICATE_UNIT_MACROS_SVH
`define ORIENT2D_SOS_PREDICATE_UNIT_MACROS_SVH

// Check that is switched off while reset is high.
`define O2S_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset.
`define O2S_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/o2s_pkg.sv =====
// ----------------------------------------------------------------------------
// o2s_pkg
// Widths, point type and result codes of the orientation predicate unit.
// ----------------------------------------------------------------------------
package o2s_pkg;

  localparam int COORD_BITS  = 24;
  localparam int ID_BITS     = 32;
  localparam int DET_WIDTH   = 51;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int DET_EXACT_W = PROD_W + 1;
  localparam int DET_CALC_W  = (DET_EXACT_W > DET_WIDTH) ? DET_EXACT_W : DET_WIDTH;

  localparam logic signed [1:0] ORI_POS = 2'sb01;
  localparam logic signed [1:0] ORI_NEG = 2'sb11;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [ID_BITS-1:0]           id;
  } pt_t;

endpackage

// ===== hw/rtl/orient2d_sos_predicate_unit.sv =====
// ----------------------------------------------------------------------------
// orient2d_sos_predicate_unit: exact 2D orientation with symbolic tie break
// A result passes through the input, product and output registers before it is valid on the outputs.
// Throughput: one item per cycle while out_stall does not hold the pipeline; each of the three stages holds one item.
// Reset clears only the stage valid flags; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module orient2d_sos_predicate_unit
  import o2s_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic [ID_BITS-1:0]           a_id,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic [ID_BITS-1:0]           b_id,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  input  logic [ID_BITS-1:0]           c_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [1:0]            orientation,
  output logic signed [DET_WIDTH-1:0]  determinant
);

  // Stage 1 is the input register. It captures the three points as they
  // arrive, so the multipliers of stage 2 start from registered operands.
  pt_t  pa, pb, pc;
  logic s1_valid;
  logic s1_stall;
  logic s1_adv;

  // Stage 2 holds the two cross products and the tie-break sign.
  logic                     s2_valid;
  logic                     s2_stall;
  logic signed [PROD_W-1:0] prod_l;
  logic signed [PROD_W-1:0] prod_r;
  logic                     tie_neg;

  // Each stage advances when it is empty or when the stage after it takes
  // its item, so a bubble anywhere is squeezed out and a waiting result in
  // the output register does not hold back stages that still have room.
  assign s1_adv   = !s1_valid || !s1_stall;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      pa <= '{x: a_x, y: a_y, id: a_id};
      pb <= '{x: b_x, y: b_y, id: b_id};
      pc <= '{x: c_x, y: c_y, id: c_id};
    end
  end

  // Stage 2: differences against point c, the two signed multiplies of the
  // determinant, and the sort-by-id tie break, which is only used when the
  // determinant turns out to be zero.
  o2s_prod_stage u_prod_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_stall (s1_stall),
    .a        (pa),
    .b        (pb),
    .c        (pc),
    .dn_valid (s2_valid),
    .dn_stall (s2_stall),
    .prod_l   (prod_l),
    .prod_r   (prod_r),
    .tie_neg  (tie_neg)
  );

  // Stage 3: one wide subtract gives the exact determinant; its sign, or the
  // tie-break sign when it is zero, becomes the orientation.
  o2s_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (s2_valid),
    .up_stall    (s2_stall),
    .prod_l      (prod_l),
    .prod_r      (prod_r),
    .tie_neg     (tie_neg),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .orientation (orientation),
    .determinant (determinant)
  );

endmodule

// ===== hw/rtl/o2s_tiebreak.sv =====
// ----------------------------------------------------------------------------
// o2s_tiebreak
// Symbolic tie break for collinear points: sorts the points by id with swap
// parity and picks the sign from the first unequal coordinate comparison.
// ----------------------------------------------------------------------------
module o2s_tiebreak
  import o2s_pkg::*;
(
  input  pt_t  a,
  input  pt_t  b,
  input  pt_t  c,
  output logic tie_neg
);

  pt_t  s1_0, s1_1, s2_1, s2_2, p0, p1, p2;
  logic sw1, sw2, sw3, par_neg;

  // Three stable compare-exchange steps, the same order as a bubble sort.
  always_comb begin
    sw1  = (b.id < a.id);
    s1_0 = sw1 ? b : a;
    s1_1 = sw1 ? a : b;
    sw2  = (c.id < s1_1.id);
    s2_1 = sw2 ? c : s1_1;
    s2_2 = sw2 ? s1_1 : c;
    sw3  = (s2_1.id < s1_0.id);
    p0   = sw3 ? s2_1 : s1_0;
    p1   = sw3 ? s1_0 : s2_1;
    p2   = s2_2;
    par_neg = sw1 ^ sw2 ^ sw3;
  end

  always_comb begin
    if (p1.x != p2.x) begin
      tie_neg = (p1.x > p2.x) ^ par_neg;
    end else if (p1.y != p2.y) begin
      tie_neg = (p1.y < p2.y) ^ par_neg;
    end else if (p0.x != p2.x) begin
      tie_neg = (p0.x < p2.x) ^ par_neg;
    end else begin
      tie_neg = par_neg;
    end
  end

endmodule

// ===== hw/rtl/o2s_prod_stage.sv =====
// ----------------------------------------------------------------------------
// o2s_prod_stage
// Forms the coordinate differences, the two cross products and the tie-break
// sign, and holds them in a pipeline register.
// ----------------------------------------------------------------------------
module o2s_prod_stage
  import o2s_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  output logic                     up_stall,
  input  pt_t                      a,
  input  pt_t                      b,
  input  pt_t                      c,
  output logic                     dn_valid,
  input  logic                     dn_stall,
  output logic signed [PROD_W-1:0] prod_l,
  output logic signed [PROD_W-1:0] prod_r,
  output logic                     tie_neg
);

  logic signed [DIFF_W-1:0] dax, day, dbx, dby;
  logic signed [PROD_W-1:0] prod_l_next, prod_r_next;
  logic                     tie_neg_next;
  logic                     adv;

  assign dax = DIFF_W'(a.x) - DIFF_W'(c.x);
  assign day = DIFF_W'(a.y) - DIFF_W'(c.y);
  assign dbx = DIFF_W'(b.x) - DIFF_W'(c.x);
  assign dby = DIFF_W'(b.y) - DIFF_W'(c.y);

  assign prod_l_next = PROD_W'(dax) * PROD_W'(dby);
  assign prod_r_next = PROD_W'(day) * PROD_W'(dbx);

  o2s_tiebreak u_tiebreak (
    .a       (a),
    .b       (b),
    .c       (c),
    .tie_neg (tie_neg_next)
  );

  assign adv      = !dn_valid || !dn_stall;
  assign up_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      prod_l  <= prod_l_next;
      prod_r  <= prod_r_next;
      tie_neg <= tie_neg_next;
    end
  end

endmodule

// ===== hw/rtl/o2s_out_stage.sv =====
// ----------------------------------------------------------------------------
// o2s_out_stage
// Subtracts the cross products, derives the orientation sign and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module o2s_out_stage
  import o2s_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_stall,
  input  logic signed [PROD_W-1:0]    prod_l,
  input  logic signed [PROD_W-1:0]    prod_r,
  input  logic                        tie_neg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [1:0]           orientation,
  output logic signed [DET_WIDTH-1:0] determinant
);

  logic signed [DET_CALC_W-1:0] det;
  logic signed [1:0]            orientation_next;
  logic                         adv;

  assign det = DET_CALC_W'(prod_l) - DET_CALC_W'(prod_r);

  // The exact determinant decides whenever it is nonzero.
  always_comb begin
    if (det == '0) begin
      orientation_next = tie_neg ? ORI_NEG : ORI_POS;
    end else begin
      orientation_next = det[DET_CALC_W-1] ? ORI_NEG : ORI_POS;
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign up_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      orientation <= orientation_next;
      determinant <= det[DET_WIDTH-1:0];
    end
  end

endmodule

// ===== hw/rtl/o2s_checker.sv =====
// ----------------------------------------------------------------------------
// o2s_checker
// Port-level checks on the orientation predicate unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "orient2d_sos_predicate_unit_macros.svh"

module o2s_checker
  import o2s_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [1:0]           orientation,
  input logic signed [DET_WIDTH-1:0] determinant
);

  `O2S_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid right after reset")
  `O2S_ASSERT(a_hold_valid, clk, rst, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `O2S_ASSERT(a_ori_code, clk, rst, out_valid |-> (orientation == ORI_POS) || (orientation == ORI_NEG), "orientation is zero or invalid")
  `O2S_ASSERT(a_det_sign, clk, rst, out_valid && (determinant != '0) |-> orientation == (determinant[DET_WIDTH-1] ? ORI_NEG : ORI_POS), "orientation disagrees with determinant sign")

endmodule

bind orient2d_sos_predicate_unit o2s_checker u_o2s_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .orientation (orientation),
  .determinant (determinant)
);
